// ----- rtl/core/dod_pkg.sv -----
`timescale 1ns / 1ps

package dod_pkg;

    // field widths
    localparam int TAG_W = 16;
    localparam int DL_W  = 32;
    localparam int OP_W  = 2;
    localparam int KIND_W = 2;

    // default queue depth
    localparam int QUEUE_DEPTH_DEF = 16;

    // results of one deadline check are capped at this many items
    localparam int MAX_RUN   = 16;
    localparam int RUN_CNT_W = $clog2(MAX_RUN);

    // operation codes
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_READY   = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [DL_W-1:0]  deadline;
    } entry_t;

    // command broadcast to every cell of the queue
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   entry;
    } cell_ctl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   keep;
        entry_t entry;
    } cell_link_t;

endpackage

// ----- rtl/core/dod_if.sv -----
`timescale 1ns / 1ps

// job channel into the dispatcher
interface dod_job_if;
    logic                        valid;
    logic                        ready;
    logic [dod_pkg::OP_W-1:0]    operation;
    logic [dod_pkg::TAG_W-1:0]   job_tag;
    logic [dod_pkg::DL_W-1:0]    job_deadline;
    logic [dod_pkg::DL_W-1:0]    current_time;

    modport source (output valid, operation, job_tag, job_deadline, current_time,
                    input ready);
    modport sink   (input valid, operation, job_tag, job_deadline, current_time,
                    output ready);
endinterface

// result channel out of the dispatcher
interface dod_result_if;
    logic                        valid;
    logic                        ready;
    logic [dod_pkg::KIND_W-1:0]  result_kind;
    logic [dod_pkg::TAG_W-1:0]   result_tag;
    logic [dod_pkg::DL_W-1:0]    result_deadline;
    logic                        last_of_run;

    modport source (output valid, result_kind, result_tag, result_deadline, last_of_run,
                    input ready);
    modport sink   (input valid, result_kind, result_tag, result_deadline, last_of_run,
                    output ready);
endinterface

// ----- rtl/core/deadline_ordered_job_dispatcher.sv -----
`timescale 1ns / 1ps

// Earliest-deadline-first dispatcher for a single worker.
// jobs carries requests (operation 0), worker-ready events (1) and deadline
// checks (2); results carries dispatch, expiry and reject items, with
// last_of_run set on the final item caused by one job-channel item.
// Waiting jobs sit in a row of QUEUE_DEPTH cells kept sorted by deadline,
// head in cell 0; on an insert every cell compares its deadline against
// the new job in parallel, and a head removal shifts every cell forward.
// A request or ready event is taken and its result appears in the output
// register on the next cycle, so one such item per cycle is sustained
// while the receiver keeps up. After a deadline check is taken, jobs.ready
// stays low until the expired jobs (at most 16) have been emitted, or until
// the head is found unexpired. The output register decouples the
// two sides: a new item is taken while a result is being taken in the same
// cycle. When the receiver stalls, the result holds and jobs.ready drops
// until the register frees up. Reset empties the queue and marks the
// worker free.
module deadline_ordered_job_dispatcher
#(
    parameter int QUEUE_DEPTH = dod_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    dod_job_if.sink              jobs,
    dod_result_if.source         results
);

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic                            busy_reg;
    logic                            busy_next;
    logic [dod_pkg::RUN_CNT_W-1:0]   cnt_reg;
    logic [dod_pkg::RUN_CNT_W-1:0]   cnt_next;
    logic [dod_pkg::DL_W-1:0]        now_reg;
    logic [dod_pkg::DL_W-1:0]        now_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [dod_pkg::KIND_W-1:0]      out_kind_reg;
    logic [dod_pkg::KIND_W-1:0]      out_kind_next;
    dod_pkg::entry_t                 out_entry_reg;
    dod_pkg::entry_t                 out_entry_next;
    logic                            out_last_reg;
    logic                            out_last_next;

    dod_pkg::cell_ctl_t              cell_ctl;
    dod_pkg::cell_link_t             link      [QUEUE_DEPTH];
    dod_pkg::cell_link_t             prev_link [QUEUE_DEPTH];
    dod_pkg::cell_link_t             next_link [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]          valid_vec;

    logic                            out_free;
    logic                            head_exp;
    logic                            next_exp;
    logic                            run_last;
    dod_pkg::entry_t                 new_entry;

    // row of queue cells
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign prev_link[gi] = '{valid: 1'b0, keep: 1'b1, entry: '0};
            end
            else
            begin : g_mid
                assign prev_link[gi] = link[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign next_link[gi] = '{valid: 1'b0, keep: 1'b0, entry: '0};
            end
            else
            begin : g_inner
                assign next_link[gi] = link[gi+1];
            end
            assign valid_vec[gi] = link[gi].valid;

            dod_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (cell_ctl),
                .prev  (prev_link[gi]),
                .next  (next_link[gi]),
                .link  (link[gi])
            );
        end
    endgenerate

    assign new_entry.tag      = jobs.job_tag;
    assign new_entry.deadline = jobs.job_deadline;

    // handshake
    assign out_free    = !out_valid_reg || results.ready;
    assign jobs.ready  = (state_reg == ST_IDLE) && out_free;

    assign results.valid           = out_valid_reg;
    assign results.result_kind     = out_kind_reg;
    assign results.result_tag      = out_entry_reg.tag;
    assign results.result_deadline = out_entry_reg.deadline;
    assign results.last_of_run     = out_last_reg;

    // expiry of the head and of the job behind it
    assign head_exp = link[0].valid && (now_reg >= link[0].entry.deadline);
    assign next_exp = link[1].valid && (now_reg >= link[1].entry.deadline);
    assign run_last = (cnt_reg == dod_pkg::RUN_CNT_W'(dod_pkg::MAX_RUN - 1)) || !next_exp;

    // control and result selection
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_kind_next  = out_kind_reg;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;
        cell_ctl.op    = dod_pkg::CELL_HOLD;
        cell_ctl.entry = new_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (jobs.valid && jobs.ready)
                begin
                    unique case (jobs.operation)
                        dod_pkg::OP_REQUEST:
                        begin
                            out_entry_next = new_entry;
                            out_last_next  = 1'b1;
                            if (!busy_reg)
                            begin
                                busy_next      = 1'b1;
                                out_valid_next = 1'b1;
                                out_kind_next  = dod_pkg::KIND_DISPATCH;
                            end
                            else if (jobs.current_time >= jobs.job_deadline)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = dod_pkg::KIND_EXPIRED;
                            end
                            else if (link[QUEUE_DEPTH-1].valid)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = dod_pkg::KIND_REJECT;
                            end
                            else
                            begin
                                cell_ctl.op = dod_pkg::CELL_INSERT;
                            end
                        end
                        dod_pkg::OP_READY:
                        begin
                            if (busy_reg)
                            begin
                                if (!link[0].valid)
                                begin
                                    busy_next = 1'b0;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    out_kind_next  = dod_pkg::KIND_DISPATCH;
                                    out_entry_next = link[0].entry;
                                    out_last_next  = 1'b1;
                                    cell_ctl.op    = dod_pkg::CELL_SHIFT;
                                end
                            end
                        end
                        dod_pkg::OP_CHECK:
                        begin
                            now_next   = jobs.current_time;
                            cnt_next   = '0;
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (!head_exp)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = dod_pkg::KIND_EXPIRED;
                    out_entry_next = link[0].entry;
                    out_last_next  = run_last;
                    cell_ctl.op    = dod_pkg::CELL_SHIFT;
                    cnt_next       = cnt_reg + 1'b1;
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        out_kind_reg  <= out_kind_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    // occupied cells always form a run starting at the head
    a_queue_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & QUEUE_DEPTH'(valid_vec + 1'b1)) == '0)
        else $error("queue cells not packed toward the head");

    // jobs wait only while the worker is busy
    a_queue_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        link[0].valid |-> busy_reg)
        else $error("jobs queued while worker free");

    // head never has a later deadline than the job behind it
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (link[0].valid && link[1].valid) |->
            (link[0].entry.deadline <= link[1].entry.deadline))
        else $error("queue head out of deadline order");

    // no job taken while an expiry run is in progress
    a_check_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> !jobs.ready)
        else $error("job taken during deadline check");

    // a run that emitted its last item returns to idle
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && head_exp && out_free && run_last)
            |=> (state_reg == ST_IDLE))
        else $error("deadline check did not finish after last item");

endmodule

// ----- rtl/core/dod_cell.sv -----
`timescale 1ns / 1ps

module dod_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  dod_pkg::cell_ctl_t  ctl,
    input  dod_pkg::cell_link_t prev,
    input  dod_pkg::cell_link_t next,
    output dod_pkg::cell_link_t link
);

    logic            valid_reg;
    logic            valid_next;
    dod_pkg::entry_t entry_reg;
    dod_pkg::entry_t entry_next;
    logic            keep;

    // entry stays put on insert when it is not later than the new job
    assign keep = valid_reg && (entry_reg.deadline <= ctl.entry.deadline);

    assign link.valid = valid_reg;
    assign link.keep  = keep;
    assign link.entry = entry_reg;

    // next contents of this cell
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (ctl.op)
            dod_pkg::CELL_INSERT:
            begin
                if (keep)
                begin
                    valid_next = valid_reg;
                end
                else if (prev.valid && !prev.keep)
                begin
                    valid_next = 1'b1;
                    entry_next = prev.entry;
                end
                else if (prev.keep)
                begin
                    valid_next = 1'b1;
                    entry_next = ctl.entry;
                end
            end
            dod_pkg::CELL_SHIFT:
            begin
                valid_next = next.valid;
                entry_next = next.entry;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // job payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- bench/deadline_ordered_job_dispatcher_tb.sv -----
`timescale 1ns / 1ps

module deadline_ordered_job_dispatcher_tb;

    import dod_pkg::*;

    localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int RANDOM_JOBS  = 75;
    localparam int STALL_CYCLES = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 200000;

    // operation code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic [DL_W-1:0]   deadline;
        logic [DL_W-1:0]   now_s;
        bit                typed;
        logic [KIND_W-1:0] kind;
    } job_item_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [DL_W-1:0]   deadline;
        logic              last;
    } dispatch_result_t;

    logic clk;
    logic rst_n;

    dod_job_if    jobs();
    dod_result_if results();

    deadline_ordered_job_dispatcher #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .jobs    (jobs),
        .results (results)
    );

    // dispatcher model state
    bit               worker_busy;
    entry_t           waiting_jobs[$];
    dispatch_result_t fresh_results[$];
    dispatch_result_t awaited_results[$];

    job_item_t        directed_rows[$];
    logic [DL_W-1:0]  sim_clock;
    bit               steady_run;
    bit               hold_wanted;
    bit               hold_done;
    int               mismatch_count;
    int               cycle_count;

    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic note_result(input logic [KIND_W-1:0] kind, input entry_t job);
        dispatch_result_t r;
        r.kind     = kind;
        r.tag      = job.tag;
        r.deadline = job.deadline;
        r.last     = 1'b0;
        fresh_results.push_back(r);
    endtask

    // earliest-deadline-first behavior of one accepted item
    task automatic advance_dispatcher(input job_item_t it);
        entry_t job;
        int     pos;
        int     run;
        job.tag      = it.tag;
        job.deadline = it.deadline;
        fresh_results.delete();
        case (it.op)
            OP_REQUEST:
            begin
                if (!worker_busy)
                begin
                    worker_busy = 1'b1;
                    note_result(KIND_DISPATCH, job);
                end
                else if (it.now_s >= it.deadline)
                    note_result(KIND_EXPIRED, job);
                else if (waiting_jobs.size() >= QUEUE_DEPTH)
                    note_result(KIND_REJECT, job);
                else
                begin
                    // equal deadlines keep arrival order
                    pos = 0;
                    while (pos < waiting_jobs.size() && waiting_jobs[pos].deadline <= it.deadline)
                        pos++;
                    waiting_jobs.insert(pos, job);
                end
            end
            OP_READY:
            begin
                if (worker_busy)
                begin
                    if (waiting_jobs.size() == 0)
                        worker_busy = 1'b0;
                    else
                        note_result(KIND_DISPATCH, waiting_jobs.pop_front());
                end
            end
            OP_CHECK:
            begin
                run = 0;
                while (waiting_jobs.size() > 0 && run < MAX_RUN
                       && it.now_s >= waiting_jobs[0].deadline)
                begin
                    note_result(KIND_EXPIRED, waiting_jobs.pop_front());
                    run++;
                end
            end
            default:
            begin
            end
        endcase
        if (fresh_results.size() > 0)
            fresh_results[fresh_results.size() - 1].last = 1'b1;
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                           input logic [DL_W-1:0] deadline, input logic [DL_W-1:0] now_s,
                           input bit typed, input logic [KIND_W-1:0] kind);
        job_item_t it;
        it.op       = op;
        it.tag      = tag;
        it.deadline = deadline;
        it.now_s    = now_s;
        it.typed    = typed;
        it.kind     = kind;
        directed_rows.push_back(it);
    endtask

    // random item drawn around a running clock, with some noise
    function automatic job_item_t random_job();
        job_item_t   it;
        int unsigned pick;
        pick        = $urandom_range(99);
        sim_clock   = sim_clock + $urandom_range(12);
        it.typed    = 1'b0;
        it.kind     = KIND_DISPATCH;
        it.tag      = TAG_W'($urandom);
        it.deadline = $urandom;
        it.now_s    = sim_clock;
        if (pick < 50)
        begin
            it.op       = OP_REQUEST;
            it.deadline = sim_clock + $urandom_range(80) - 8;
        end
        else if (pick < 78)
            it.op = OP_READY;
        else if (pick < 95)
            it.op = OP_CHECK;
        else
            it.op = OP_UNUSED;
        if ($urandom_range(9) == 0)
        begin
            it.deadline = $urandom;
            it.now_s    = $urandom;
        end
        return it;
    endfunction

    // present one item and wait for the handshake
    task automatic offer(input job_item_t it);
        dispatch_result_t typed_result;
        while (!steady_run && $urandom_range(99) < 35)
        begin
            jobs.valid <= 1'b0;
            @(posedge clk);
        end
        jobs.valid        <= 1'b1;
        jobs.operation    <= it.op;
        jobs.job_tag      <= it.tag;
        jobs.job_deadline <= it.deadline;
        jobs.current_time <= it.now_s;
        do @(posedge clk); while (!jobs.ready);
        advance_dispatcher(it);
        if (it.typed)
        begin
            typed_result.kind     = it.kind;
            typed_result.tag      = it.tag;
            typed_result.deadline = it.deadline;
            typed_result.last     = 1'b1;
            awaited_results.push_back(typed_result);
        end
        else
        begin
            foreach (fresh_results[i])
                awaited_results.push_back(fresh_results[i]);
        end
    endtask

    // result receiver with random stalls and one long hold-off
    initial
    begin
        results.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !hold_done)
            begin
                results.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            results.ready <= steady_run || ($urandom_range(99) >= 35);
        end
    end

    // compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        dispatch_result_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: kind %0d tag %0h deadline %0h",
                       results.result_kind, results.result_tag, results.result_deadline);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (results.result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, got %0d",
                           want.kind, results.result_kind);
                    mismatch_count++;
                end
                if (results.result_tag !== want.tag)
                begin
                    $error("result_tag: expected %0h, got %0h",
                           want.tag, results.result_tag);
                    mismatch_count++;
                end
                if (results.result_deadline !== want.deadline)
                begin
                    $error("result_deadline: expected %0h, got %0h",
                           want.deadline, results.result_deadline);
                    mismatch_count++;
                end
                if (results.last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last, results.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        jobs.valid        = 1'b0;
        jobs.operation    = OP_REQUEST;
        jobs.job_tag      = '0;
        jobs.job_deadline = '0;
        jobs.current_time = '0;
        worker_busy       = 1'b0;
        steady_run        = 1'b0;
        hold_wanted       = 1'b0;
        hold_done         = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;

        // ready and check while free, unused code: all silent
        add_row(OP_READY,  16'h1234, 32'h0,        32'h0,        1'b0, KIND_DISPATCH);
        add_row(OP_CHECK,  16'h4321, 32'h0,        32'hFFFFFFFF, 1'b0, KIND_DISPATCH);
        add_row(OP_UNUSED, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, KIND_DISPATCH);
        // free worker takes even an expired job
        add_row(OP_REQUEST, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, KIND_DISPATCH);
        add_row(OP_REQUEST, 16'h0000, 32'h0,        32'h0,        1'b1, KIND_EXPIRED);
        // fill the queue, repeated deadlines test arrival order
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            add_row(OP_REQUEST, TAG_W'(16'h0010 + i), 32'd20 + 32'd10 * (i % 3), 32'd5,
                    1'b0, KIND_DISPATCH);
        add_row(OP_REQUEST, 16'h001F, 32'hFFFFFFFF, 32'd5, 1'b0, KIND_DISPATCH);
        // full queue: reject, but expiry wins over full
        add_row(OP_REQUEST, 16'hABCD, 32'd1000, 32'd5, 1'b1, KIND_REJECT);
        add_row(OP_REQUEST, 16'h5555, 32'd7,    32'd7, 1'b1, KIND_EXPIRED);
        // longest expiry burst, then the worker goes free
        add_row(OP_CHECK, 16'h0, 32'h0, 32'hFFFFFFFF, 1'b0, KIND_DISPATCH);
        add_row(OP_READY, 16'h0, 32'h0, 32'h0,        1'b0, KIND_DISPATCH);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i]);

        sim_clock = $urandom;
        for (int i = 0; i < RANDOM_JOBS; i++)
        begin
            steady_run = (i >= 45 && i < 70);
            if (i == 15)
                hold_wanted = 1'b1;
            if (i == 35)
            begin
                // let every outstanding result drain before going on
                jobs.valid <= 1'b0;
                do @(posedge clk); while (awaited_results.size() != 0);
            end
            offer(random_job());
        end
        steady_run = 1'b0;

        jobs.valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
